// ===== hw/rtl/hbs_pkg.sv =====
package hbs_pkg;

  localparam int unsigned COORD_W = 5;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned H_W     = 16;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 opcode;
    logic [COORD_W-1:0]  grid_col;
    logic [COORD_W-1:0]  grid_row;
    logic [PIX_W-1:0]    pixel_value;
    logic signed [15:0]  query_x;
    logic signed [15:0]  query_z;
  } req_t;

  typedef struct packed {
    logic [H_W-1:0] height_out;
    logic           out_of_range;
  } rsp_t;

  // world bounds in Q8.8
  localparam logic signed [15:0] QBOUND    = 16'sd25600;
  localparam logic signed [15:0] QBOUND_LO = -16'sd25600;

  // cell fraction denominator: 51200 = 50 << 10
  localparam logic [15:0]  SPAN        = 16'd51200;
  localparam int unsigned  SPAN_SHIFT  = 10;

  // floor(m / 50) = (m * 20972) >> 20 for m < 43690
  localparam logic [14:0]  DIV50_MUL   = 15'd20972;
  localparam int unsigned  DIV50_SHIFT = 20;

  // height = floor((8192*(255-p) + 25) / 51), reciprocal of 51
  localparam logic [7:0]   PIX_MAX     = 8'd255;
  localparam logic [4:0]   LOAD_BIAS   = 5'd25;
  localparam logic [26:0]  DIV51_MUL   = 27'd84215046;
  localparam int unsigned  DIV51_SHIFT = 32;

  // blend / SPAN^2 = ((acc >> 20) * M) >> 40, M ~ 2^40 / 2500
  localparam logic [47:0]  ROUND_HALF    = 48'd1310720000;
  localparam int unsigned  ACC_SHIFT     = 20;
  localparam logic [28:0]  DIV2500_MUL   = 29'd439804652;
  localparam int unsigned  DIV2500_SHIFT = 40;

  localparam logic [H_W-1:0] HEIGHT_MAX = 16'd40960;

endpackage

// ===== hw/rtl/hbs_if.sv =====
interface hbs_req_if import hbs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hbs_rsp_if import hbs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hbs_bank.sv =====
module hbs_bank import hbs_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [H_W-1:0] wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output logic [H_W-1:0] rd_data
);

  logic [H_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/heightfield_bilinear_sampler.sv =====
// Bilinear heightfield sampler.
// req channel: one request per accepted valid/ready beat. opcode OP_LOAD
//   stores the height of grid point (grid_col, grid_row) from pixel_value
//   and produces no response; OP_QUERY samples the grid at
//   (query_x, query_z) and produces exactly one response.
// rsp channel: height_out (Q5.11) and out_of_range, in request order.
// Throughput: one request per cycle, loads and queries mixed freely, except while an rsp stall holds req.ready low.
// Pipeline: seven register stages; a query passes through stages 1 to 7 in order
//   and is presented on rsp from the stage 7 output register.
//   A load is written to the store as it leaves stage 2, so a query right
//   behind it already sees the new height.
// The grid is held in four single-port-read banks split by column and row
//   parity, so the four corners of a cell are read in the same cycle.
// Reset clears only the stage valid bits; the height store is undefined
//   until loaded, and every grid point must be loaded before a query uses it.
// When rsp stalls, each stage holds while the one after it is full and held;
//   bubbles close up and req.ready falls only once all seven stages are occupied.
module heightfield_bilinear_sampler import hbs_pkg::*; #(
  parameter int unsigned GRID_POINTS = 32
) (
  input  logic       clk,
  input  logic       rst,
  hbs_req_if.sink    req,
  hbs_rsp_if.source  rsp
);

  localparam int unsigned IW   = $clog2(GRID_POINTS);
  localparam int unsigned HALF = (GRID_POINTS + 1) / 2;
  localparam int unsigned HW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned AW   = 2 * HW;
  localparam int unsigned PW   = 16 + IW;
  localparam int unsigned MW   = PW - SPAN_SHIFT;
  localparam int unsigned LW   = (IW + 1 > COORD_W) ? IW + 1 : COORD_W;
  localparam logic [IW-1:0] CELLS    = IW'(GRID_POINTS - 1);
  localparam logic [LW-1:0] GRID_LIM = LW'(GRID_POINTS);

  // per-stage advance
  logic v1, v2, v3, v4, v5, v6, v7;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

  assign adv7 = !v7 || rsp.ready;
  assign adv6 = !v6 || adv7;
  assign adv5 = !v5 || adv6;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign req.ready = adv1;

  // ---------------- stage 1: range check, u*I, load numerator
  logic [15:0]   ux_in, uz_in;
  logic          oor_in;
  logic [PW-1:0] px_in, pz_in;
  logic [7:0]    q_in;
  logic [20:0]   n_in;
  logic [LW-1:0] col_in, row_in;

  assign oor_in = (req.data.query_x >= QBOUND) || (req.data.query_x <= QBOUND_LO) ||
                  (req.data.query_z >= QBOUND) || (req.data.query_z <= QBOUND_LO);
  assign ux_in  = 16'($unsigned(req.data.query_x + QBOUND));
  assign uz_in  = 16'($unsigned(req.data.query_z + QBOUND));
  assign px_in  = PW'(ux_in) * PW'(CELLS);
  assign pz_in  = PW'(uz_in) * PW'(CELLS);
  assign q_in   = PIX_MAX - req.data.pixel_value;
  assign n_in   = {q_in, 13'b0} + 21'(LOAD_BIAS);
  assign col_in = LW'(req.data.grid_col);
  assign row_in = LW'(req.data.grid_row);

  op_t           op1;
  logic          oor1, wok1;
  logic [PW-1:0] px1, pz1;
  logic [20:0]   n1;
  logic [LW-1:0] col1, row1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= req.valid;
    end
    if (adv1) begin
      op1  <= req.data.opcode;
      oor1 <= oor_in;
      wok1 <= (col_in < GRID_LIM) && (row_in < GRID_LIM);
      px1  <= px_in;
      pz1  <= pz_in;
      n1   <= n_in;
      col1 <= col_in;
      row1 <= row_in;
    end
  end

  // ---------------- stage 2: cell index, load height
  logic [MW+14:0] iprod, jprod;
  logic [47:0]    hprod;

  assign iprod = (MW+15)'(px1[PW-1:SPAN_SHIFT]) * (MW+15)'(DIV50_MUL);
  assign jprod = (MW+15)'(pz1[PW-1:SPAN_SHIFT]) * (MW+15)'(DIV50_MUL);
  assign hprod = 48'(n1) * 48'(DIV51_MUL);

  op_t            op2;
  logic           oor2, wok2;
  logic [PW-1:0]  px2, pz2;
  logic [IW-1:0]  i2, j2;
  logic [H_W-1:0] hgt2;
  logic [LW-1:0]  col2, row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      op2  <= op1;
      oor2 <= oor1;
      wok2 <= wok1;
      px2  <= px1;
      pz2  <= pz1;
      i2   <= iprod[DIV50_SHIFT +: IW];
      j2   <= jprod[DIV50_SHIFT +: IW];
      hgt2 <= hprod[DIV51_SHIFT +: H_W];
      col2 <= col1;
      row2 <= row1;
    end
  end

  // ---------------- height store: four parity banks
  logic           wr_go;
  logic [AW-1:0]  wr_addr;
  logic [H_W-1:0] rd [2][2];
  logic [IW:0]    ic, ic1, jc, jc1;

  assign wr_go   = v2 && (op2 == OP_LOAD) && wok2 && adv3;
  assign wr_addr = {col2[HW:1], row2[HW:1]};
  assign ic      = {1'b0, i2};
  assign jc      = {1'b0, j2};
  assign ic1     = ic + 1'b1;
  assign jc1     = jc + 1'b1;

  for (genvar ga = 0; ga < 2; ga++) begin : g_col
    for (genvar gb = 0; gb < 2; gb++) begin : g_row
      logic [IW:0]   cc, rc;
      logic [AW-1:0] rd_addr;

      always_comb begin
        cc      = (i2[0] == 1'(ga)) ? ic : ic1;
        rc      = (j2[0] == 1'(gb)) ? jc : jc1;
        rd_addr = {cc[HW:1], rc[HW:1]};
      end

      hbs_bank #(.AW(AW)) u_bank (
        .clk     (clk),
        .wr_en   (wr_go && (col2[0] == 1'(ga)) && (row2[0] == 1'(gb))),
        .wr_addr (wr_addr),
        .wr_data (hgt2),
        .rd_en   (adv3),
        .rd_addr (rd_addr),
        .rd_data (rd[ga][gb])
      );
    end
  end

  // ---------------- stage 3: fraction numerators, corner read
  logic [PW-1:0] s_full, t_full;

  assign s_full = px2 - PW'(i2) * PW'(SPAN);
  assign t_full = pz2 - PW'(j2) * PW'(SPAN);

  logic        oor3, ip3, jp3;
  logic [15:0] s3, t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2 && (op2 == OP_QUERY);
    end
    if (adv3) begin
      oor3 <= oor2;
      ip3  <= i2[0];
      jp3  <= j2[0];
      s3   <= s_full[15:0];
      t3   <= t_full[15:0];
    end
  end

  // ---------------- stage 4: corner weights, corner heights
  logic [15:0] ds, dt;

  assign ds = SPAN - s3;
  assign dt = SPAN - t3;

  logic                   oor4;
  logic [3:0][31:0]       w4;
  logic [3:0][H_W-1:0]    h4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= v3;
    end
    if (adv4) begin
      oor4  <= oor3;
      w4[0] <= 32'(ds) * 32'(dt);
      w4[1] <= 32'(s3) * 32'(dt);
      w4[2] <= 32'(ds) * 32'(t3);
      w4[3] <= 32'(s3) * 32'(t3);
      h4[0] <= rd[ip3][jp3];
      h4[1] <= rd[!ip3][jp3];
      h4[2] <= rd[ip3][!jp3];
      h4[3] <= rd[!ip3][!jp3];
    end
  end

  // ---------------- stage 5: weighted corners
  logic             oor5;
  logic [3:0][47:0] p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv5) begin
      v5 <= v4;
    end
    if (adv5) begin
      oor5 <= oor4;
      for (int k = 0; k < 4; k++) begin
        p5[k] <= 48'(w4[k]) * 48'(h4[k]);
      end
    end
  end

  // ---------------- stage 6: sum with rounding
  logic        oor6;
  logic [47:0] acc6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv6) begin
      v6 <= v5;
    end
    if (adv6) begin
      oor6 <= oor5;
      acc6 <= p5[0] + p5[1] + p5[2] + p5[3] + ROUND_HALF;
    end
  end

  // ---------------- stage 7: divide by SPAN^2, output register
  logic [56:0] qprod;

  assign qprod = 57'(acc6[47:ACC_SHIFT]) * 57'(DIV2500_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv7) begin
      v7 <= v6;
    end
    if (adv7) begin
      rsp.data.out_of_range <= oor6;
      rsp.data.height_out   <= oor6 ? '0 : qprod[DIV2500_SHIFT +: H_W];
    end
  end

  assign rsp.valid = v7;

  // ---------------- checks
  a_cell_index: assert property (@(posedge clk) disable iff (rst)
    v2 && (op2 == OP_QUERY) && !oor2 |-> (i2 < CELLS) && (j2 < CELLS))
    else $error("cell index outside grid");

  a_fraction: assert property (@(posedge clk) disable iff (rst)
    v3 && !oor3 |-> (s3 < SPAN) && (t3 < SPAN))
    else $error("cell fraction not below denominator");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !adv4 |=> v4 && $stable(w4) && $stable(h4) && $stable(oor4))
    else $error("stalled stage changed");

  a_height_max: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.out_of_range |-> rsp.data.height_out <= HEIGHT_MAX)
    else $error("blend above largest height");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import hbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_N = 32;

  logic clk;
  logic rst;

  hbs_req_if req_if ();
  hbs_rsp_if rsp_if ();

  heightfield_bilinear_sampler #(
    .GRID_POINTS(GRID_N)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [H_W-1:0] grid_height [GRID_N][GRID_N];
  rsp_t           height_exp_q [$];
  int             errors;
  bit             idle_on;
  bit             rsp_hold;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [H_W-1:0] pixel_to_height(logic [PIX_W-1:0] p);
    longint unsigned num;
    num = 40960 * (255 - longint'(p));
    return H_W'((num + 127) / 255);
  endfunction

  function automatic rsp_t sample_height(logic signed [15:0] qx, logic signed [15:0] qz);
    longint unsigned ux, uz, px, pz, ci, cj, s, t, dd, acc;
    rsp_t r;
    r = '0;
    if (qx >= QBOUND || qx <= QBOUND_LO || qz >= QBOUND || qz <= QBOUND_LO) begin
      r.out_of_range = 1'b1;
      return r;
    end
    dd = longint'(SPAN);
    ux = longint'(int'(qx) + 25600);
    uz = longint'(int'(qz) + 25600);
    px = ux * (GRID_N - 1);
    pz = uz * (GRID_N - 1);
    ci = px / dd;
    cj = pz / dd;
    s  = px - ci * dd;
    t  = pz - cj * dd;
    acc = (dd - s) * (dd - t) * grid_height[ci][cj]
        + s * (dd - t) * grid_height[ci + 1][cj]
        + (dd - s) * t * grid_height[ci][cj + 1]
        + s * t * grid_height[ci + 1][cj + 1];
    acc = (acc + (dd * dd) / 2) / (dd * dd);
    r.height_out = H_W'(acc);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(req_t r);
    while (idle_on && $urandom_range(99) < 37) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    if (r.opcode == OP_LOAD)
      grid_height[r.grid_col][r.grid_row] = pixel_to_height(r.pixel_value);
    else
      height_exp_q.push_back(sample_height(r.query_x, r.query_z));
    @(negedge clk);
  endtask

  task automatic send_load(int col, int row, int pix);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom});
    r.opcode      = OP_LOAD;
    r.grid_col    = COORD_W'(col);
    r.grid_row    = COORD_W'(row);
    r.pixel_value = PIX_W'(pix);
    send_req(r);
  endtask

  task automatic send_query(int x, int z);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom});
    r.opcode  = OP_QUERY;
    r.query_x = 16'(x);
    r.query_z = 16'(z);
    send_req(r);
  endtask

  function automatic int rand_inside();
    return int'($urandom_range(51198)) - 25599;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(9))
      0:       return int'($urandom_range(65535)) - 32768;
      1:       return $urandom_range(1) ? 25599 - int'($urandom_range(3))
                                        : -25599 + int'($urandom_range(3));
      2:       return $urandom_range(1) ? 25600 + int'($urandom_range(2))
                                        : -25600 - int'($urandom_range(2));
      default: return rand_inside();
    endcase
  endfunction

  // response side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst || rsp_hold)
      rsp_if.ready <= 1'b0;
    else if (idle_on && $urandom_range(99) < 37)
      rsp_if.ready <= 1'b0;
    else
      rsp_if.ready <= 1'b1;
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (height_exp_q.size() == 0) begin
        report_mismatch("unexpected response height", rsp_if.data.height_out, -1);
      end else begin
        want = height_exp_q.pop_front();
        if (rsp_if.data.height_out !== want.height_out)
          report_mismatch("height_out", rsp_if.data.height_out, want.height_out);
        if (rsp_if.data.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", rsp_if.data.out_of_range, want.out_of_range);
      end
    end
  end

  // nothing in the grid is loaded yet, so only requests outside the bounds
  task automatic test_bounds();
    send_query(25600, 0);
    send_query(-25600, 0);
    send_query(0, 25600);
    send_query(0, -25600);
    send_query(32767, -32768);
    send_query(-32768, 32767);
    send_query(25600, 25600);
    send_query(-32768, -32768);
  endtask

  task automatic test_grid_fill();
    for (int c = 0; c < GRID_N; c++)
      for (int w = 0; w < GRID_N; w++)
        send_load(c, w, $urandom_range(255));
  endtask

  task automatic test_extremes();
    send_load(0, 0, 0);
    send_load(GRID_N - 1, GRID_N - 1, 255);
    send_load(GRID_N - 1, 0, 0);
    send_load(0, GRID_N - 1, 255);
    send_query(-25599, -25599);
    send_query(25599, 25599);
    send_query(25599, -25599);
    send_query(-25599, 25599);
    send_query(0, 0);
    // load then query the same cell in the next request
    send_load(15, 15, 0);
    send_query(0, 0);
    send_load(16, 16, 255);
    send_query(1, 1);
  endtask

  task automatic test_random_mix(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 30)
        send_load($urandom_range(GRID_N - 1), $urandom_range(GRID_N - 1),
                  $urandom_range(255));
      else
        send_query(rand_coord(), rand_coord());
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random_mix(50);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    fork
      begin
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (80) @(posedge clk);
        rsp_hold = 1'b0;
      end
    join_none
    for (int k = 0; k < 30; k++)
      send_query(rand_inside(), rand_inside());
    idle_on = 1'b1;
  endtask

  initial begin
    errors       = 0;
    idle_on      = 1'b1;
    rsp_hold     = 1'b0;
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_bounds();
    test_grid_fill();
    test_extremes();
    test_random_mix(30);
    test_no_idle();
    test_backpressure();

    req_if.valid <= 1'b0;
    while (height_exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && height_exp_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
